### rtl/ttl_pkg.sv
// shared types and constants for the ttl cache table
package ttl_pkg;

  localparam int unsigned Entries  = 16;
  localparam int unsigned IdxW     = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned ClockW   = 42;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned DataW    = 64;
  localparam int unsigned TtlW     = 32;
  localparam int unsigned LimW     = 42;
  localparam int unsigned FindCap  = 16;
  localparam int unsigned MsPerS   = 1000;

  localparam logic [2:0] ReqTick   = 3'd0;
  localparam logic [2:0] ReqAdd    = 3'd1;
  localparam logic [2:0] ReqRemove = 3'd2;
  localparam logic [2:0] ReqFind   = 3'd3;
  localparam logic [2:0] ReqFlush  = 3'd4;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatInvalid = 2'd1;
  localparam logic [1:0] StatNoSpace = 2'd2;

  localparam logic KindData    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [KeyW-1:0]  lookup_key;
    logic [DataW-1:0] entry_data;
    logic [TtlW-1:0]  ttl_seconds;
    logic [4:0]       max_matches;
  } req_t;

  typedef struct packed {
    logic             result_kind;
    logic [DataW-1:0] match_data;
    logic [1:0]       status;
    logic [4:0]       found_count;
    logic             last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic             load;      // capture request
    logic             tick;      // advance clock
    logic             flush;     // clear all valid bits
    logic             scan_clr;  // reset scan index and accumulators
    logic             scan_step; // examine one slot
    logic             write;     // store the add into the picked slot
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic             scan_done; // last slot examined this cycle
    logic             emit;      // current slot gives a data word
  } sts_t;

endpackage

### rtl/ttl_cache_table.sv
// top level of the ttl cache table
// a table of ttl_pkg::Entries cached entries with expiry on a millisecond clock
// request channel: req_valid_i / req_stall_o carry one request word
// (tick, add, remove, find or flush); a word is taken when valid is high and
// stall is low. the block handles one request at a time
// result channel: rsp_valid_o / rsp_stall_i carry result words; find sends
// its matching data words first, in slot order, and every request ends with
// one summary word with last set
// order: tick, flush and rejected requests go from idle to the summary
// state; add, remove and find pass a prep state while the slot ram's
// registered read of the first slot is in flight, then walk the slots one per
// cycle unless a data word is held up; add then writes the picked slot in a
// wait state before the summary state
// the next request is taken back in idle, after the summary word is registered
// a stalled result word is held in the output register; the walk pauses on
// a data word only while the register is still full
// reset clears the valid bits, the millisecond clock and the control state;
// slot contents stay undefined until written
module ttl_cache_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  ttl_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output ttl_pkg::rsp_t rsp_o
);
  ttl_pkg::ctl_t ctl;
  ttl_pkg::sts_t sts;
  ttl_pkg::rsp_t sum;
  logic [ttl_pkg::DataW-1:0] sdata;

  // sequencer and output register
  ttl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_valid_i),
    .in_stall_o  (req_stall_o),
    .req_i       (req_i),
    .out_valid_o (rsp_valid_o),
    .out_stall_i (rsp_stall_i),
    .out_o       (rsp_o),
    .ctl_o       (ctl),
    .sts_i       (sts),
    .sum_i       (sum),
    .data_i      (sdata)
  );

  // slot storage and per-slot evaluation
  ttl_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .sum_o  (sum),
    .data_o (sdata)
  );

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.last == rsp_o.result_kind)
    else $error("last flag disagrees with word kind");
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.result_kind == ttl_pkg::KindData |->
      rsp_o.status == ttl_pkg::StatOk && rsp_o.found_count == '0)
    else $error("data word carries summary fields");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.last |-> req_stall_o)
    else $error("request taken before summary");
endmodule

### rtl/ttl_ram.sv
// generic ram with one write port, one read port and registered read
module ttl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/ttl_datapath.sv
// slot storage, scan index, expiry and match logic
module ttl_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ttl_pkg::req_t req_i,
  input  ttl_pkg::ctl_t ctl_i,
  output ttl_pkg::sts_t sts_o,
  output ttl_pkg::rsp_t sum_o,
  output logic [ttl_pkg::DataW-1:0] data_o
);
  localparam int unsigned SlotW =
    ttl_pkg::KeyW + ttl_pkg::DataW + ttl_pkg::TtlW + ttl_pkg::ClockW;

  ttl_pkg::req_t              req_q;
  logic [ttl_pkg::Entries-1:0] valid_q, valid_d;
  logic [ttl_pkg::ClockW-1:0]  uptime_q;
  // read address: next slot when stepping, else the current one
  logic [ttl_pkg::IdxW-1:0]    raddr;
  logic [ttl_pkg::IdxW-1:0]    cur_q;
  logic [ttl_pkg::CntW-1:0]    seen_q;
  logic                        have_empty_q;
  logic [ttl_pkg::IdxW-1:0]    pick_q;
  logic [ttl_pkg::ClockW-1:0]  best_q;
  logic                        have_pick_q;
  logic [4:0]                  found_q;
  logic [ttl_pkg::CntW-1:0]    emitted_q;
  logic [SlotW-1:0]            rdata;
  logic [ttl_pkg::KeyW-1:0]    s_key;
  logic [ttl_pkg::DataW-1:0]   s_data;
  logic [ttl_pkg::TtlW-1:0]    s_ttl;
  logic [ttl_pkg::ClockW-1:0]  s_birth, age;
  logic [ttl_pkg::LimW-1:0]    lim_ms;
  logic                        live, match, expired;
  logic [4:0]                  lim;

  assign {s_key, s_data, s_ttl, s_birth} = rdata;
  assign age    = uptime_q - s_birth;
  assign lim_ms = ttl_pkg::LimW'(s_ttl) * ttl_pkg::LimW'(ttl_pkg::MsPerS);
  assign expired = valid_q[cur_q] && (age >= lim_ms);
  assign live   = valid_q[cur_q] && !expired;
  assign match  = live && (s_key == req_q.lookup_key);
  assign lim    = (req_q.max_matches > 5'(ttl_pkg::FindCap)) ?
                  5'(ttl_pkg::FindCap) : req_q.max_matches;
  assign raddr  = ctl_i.scan_step ? cur_q + 1'b1 : cur_q;

  ttl_ram #(.Width(SlotW), .Depth(ttl_pkg::Entries)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ctl_i.write),
    .waddr_i (pick_q),
    .wdata_i ({req_q.lookup_key, req_q.entry_data, req_q.ttl_seconds, uptime_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sts_o.scan_done = ctl_i.scan_step &&
                           (seen_q == ttl_pkg::CntW'(ttl_pkg::Entries - 1));
  assign sts_o.emit = req_q.req_type == ttl_pkg::ReqFind &&
                      match && (emitted_q < ttl_pkg::CntW'(lim));
  assign data_o = s_data;

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.flush) begin
      valid_d = '0;
    end else if (ctl_i.scan_step) begin
      if (expired || (req_q.req_type == ttl_pkg::ReqRemove && match)) begin
        valid_d[cur_q] = 1'b0;
      end
    end else if (ctl_i.write) begin
      valid_d[pick_q] = 1'b1;
    end
  end

  always_comb begin
    sum_o = '0;
    sum_o.result_kind = ttl_pkg::KindSummary;
    sum_o.last        = 1'b1;
    case (req_q.req_type)
      ttl_pkg::ReqTick, ttl_pkg::ReqRemove, ttl_pkg::ReqFlush: begin
        sum_o.status = ttl_pkg::StatOk;
      end
      ttl_pkg::ReqAdd: begin
        sum_o.status = (req_q.ttl_seconds == '0) ? ttl_pkg::StatInvalid
                                                 : ttl_pkg::StatOk;
      end
      ttl_pkg::ReqFind: begin
        if (req_q.max_matches == '0) begin
          sum_o.status = ttl_pkg::StatInvalid;
        end else begin
          sum_o.status = (found_q > lim) ? ttl_pkg::StatNoSpace : ttl_pkg::StatOk;
          sum_o.found_count = found_q;
        end
      end
      default: begin
        sum_o.status = ttl_pkg::StatInvalid;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      uptime_q     <= '0;
      cur_q        <= '0;
      seen_q       <= '0;
      have_empty_q <= 1'b0;
      have_pick_q  <= 1'b0;
      pick_q       <= '0;
      best_q       <= '0;
      found_q      <= '0;
      emitted_q    <= '0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.tick) begin
        uptime_q <= uptime_q + 1'b1;
      end
      if (ctl_i.scan_clr) begin
        cur_q        <= '0;
        seen_q       <= '0;
        have_empty_q <= 1'b0;
        have_pick_q  <= 1'b0;
        pick_q       <= '0;
        best_q       <= '0;
        found_q      <= '0;
        emitted_q    <= '0;
      end else if (ctl_i.scan_step) begin
        cur_q   <= cur_q + 1'b1;
        seen_q  <= seen_q + 1'b1;
        if (!have_empty_q) begin
          if (!live) begin
            have_empty_q <= 1'b1;
            have_pick_q  <= 1'b1;
            pick_q       <= cur_q;
          end else if (!have_pick_q || age > best_q) begin
            have_pick_q <= 1'b1;
            pick_q      <= cur_q;
            best_q      <= age;
          end
        end
        if (match && found_q != 5'd31) begin
          found_q <= found_q + 1'b1;
        end
        if (sts_o.emit) begin
          emitted_q <= emitted_q + 1'b1;
        end
      end
    end
  end

  // scan index advances by one per step
  a_addr_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctl_i.scan_step) && !$past(ctl_i.scan_clr) |->
      cur_q == $past(cur_q) + 1'b1)
    else $error("scan index skipped");
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= ttl_pkg::CntW'(ttl_pkg::FindCap))
    else $error("too many data words");
  a_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.write |-> !ctl_i.scan_step && !ctl_i.flush)
    else $error("write overlaps scan");
endmodule

### rtl/ttl_ctrl.sv
// request sequencer and output word register
module ttl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ttl_pkg::req_t req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ttl_pkg::rsp_t out_o,
  output ttl_pkg::ctl_t ctl_o,
  input  ttl_pkg::sts_t sts_i,
  input  ttl_pkg::rsp_t sum_i,
  input  logic [ttl_pkg::DataW-1:0] data_i
);
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPrep = 5'b00010,
    StScan = 5'b00100,
    StSum  = 5'b01000,
    StWait = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic          is_add_q, is_add_d;
  logic          ov_q, ov_d;
  ttl_pkg::rsp_t od_q, od_d;
  logic          accept;
  logic          free;

  assign free        = !ov_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_o       = od_q;

  always_comb begin
    state_d  = state_q;
    is_add_d = is_add_q;
    ov_d     = ov_q && out_stall_i;
    od_d     = od_q;
    ctl_o    = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          ctl_o.load = 1'b1;
          state_d    = StPrep;
          ctl_o.scan_clr = 1'b1;
          is_add_d   = 1'b0;
          case (req_i.req_type)
            ttl_pkg::ReqTick: begin
              ctl_o.tick = 1'b1;
              state_d    = StSum;
            end
            ttl_pkg::ReqFlush: begin
              ctl_o.flush = 1'b1;
              state_d     = StSum;
            end
            ttl_pkg::ReqAdd: begin
              is_add_d = 1'b1;
              if (req_i.ttl_seconds == '0) state_d = StSum;
            end
            ttl_pkg::ReqRemove: begin
            end
            ttl_pkg::ReqFind: begin
              if (req_i.max_matches == '0) state_d = StSum;
            end
            default: begin
              state_d = StSum;
            end
          endcase
        end
      end
      StPrep: begin
        // first slot read is in flight
        state_d = StScan;
      end
      StScan: begin
        // hold the scan while a data word cannot be placed
        if (!sts_i.emit || free) begin
          ctl_o.scan_step = 1'b1;
          if (sts_i.emit) begin
            ov_d = 1'b1;
            od_d = '0;
            od_d.result_kind = ttl_pkg::KindData;
            od_d.match_data  = data_i;
          end
          if (sts_i.scan_done) begin
            state_d = is_add_q ? StWait : StSum;
          end
        end
      end
      StWait: begin
        ctl_o.write = 1'b1;
        state_d     = StSum;
      end
      StSum: begin
        if (free) begin
          ov_d    = 1'b1;
          od_d    = sum_i;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      is_add_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_add_q <= is_add_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(od_q))
    else $error("stalled word lost");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("second request taken mid-operation");
endmodule

### test/ttl_cache_table_test.sv
// testbench for the ttl cache table: directed and random requests checked against a predictor
module ttl_cache_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  ttl_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  ttl_pkg::rsp_t rsp_o;

  ttl_cache_table dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o(rsp_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of the table
  logic                       tbl_valid [ttl_pkg::Entries];
  logic [ttl_pkg::KeyW-1:0]   tbl_key   [ttl_pkg::Entries];
  logic [ttl_pkg::DataW-1:0]  tbl_data  [ttl_pkg::Entries];
  logic [ttl_pkg::TtlW-1:0]   tbl_life  [ttl_pkg::Entries];
  logic [ttl_pkg::ClockW-1:0] tbl_birth [ttl_pkg::Entries];
  logic [ttl_pkg::ClockW-1:0] now_ms;

  ttl_pkg::rsp_t pending_words[$];
  int   mismatches = 0;
  int   words_seen = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_rsp = 1'b0;

  // keys drawn from a small pool so remove and find hit often
  logic [ttl_pkg::KeyW-1:0] key_pool [4];

  function automatic logic [ttl_pkg::ClockW-1:0] age(int i);
    return now_ms - tbl_birth[i];
  endfunction

  function automatic void expire_stale();
    for (int i = 0; i < ttl_pkg::Entries; i++)
      if (tbl_valid[i] && {10'd0, age(i)} >= 52'(tbl_life[i]) * 52'(ttl_pkg::MsPerS))
        tbl_valid[i] = 1'b0;
  endfunction

  function automatic ttl_pkg::rsp_t summary(logic [1:0] st, logic [4:0] cnt);
    ttl_pkg::rsp_t r;
    r = '0;
    r.result_kind = ttl_pkg::KindSummary;
    r.status = st;
    r.found_count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  // works out the result words of one request and queues them
  function automatic void predict_request(ttl_pkg::req_t q);
    int pick;
    logic [ttl_pkg::ClockW-1:0] oldest;
    int lim;
    int found;
    ttl_pkg::rsp_t r;
    pick = -1;
    oldest = '0;
    found = 0;
    lim = int'(q.max_matches);
    case (q.req_type)
      ttl_pkg::ReqTick: begin
        now_ms = now_ms + 1'b1;
        pending_words.push_back(summary(ttl_pkg::StatOk, 5'd0));
      end
      ttl_pkg::ReqAdd: begin
        if (q.ttl_seconds == '0) begin
          pending_words.push_back(summary(ttl_pkg::StatInvalid, 5'd0));
        end else begin
          expire_stale();
          for (int i = 0; i < ttl_pkg::Entries; i++) begin
            if (!tbl_valid[i]) begin
              pick = i;
              break;
            end
            if (pick < 0 || age(i) > oldest) begin
              pick = i;
              oldest = age(i);
            end
          end
          tbl_valid[pick] = 1'b1;
          tbl_key[pick] = q.lookup_key;
          tbl_data[pick] = q.entry_data;
          tbl_life[pick] = q.ttl_seconds;
          tbl_birth[pick] = now_ms;
          pending_words.push_back(summary(ttl_pkg::StatOk, 5'd0));
        end
      end
      ttl_pkg::ReqRemove: begin
        expire_stale();
        for (int i = 0; i < ttl_pkg::Entries; i++)
          if (tbl_valid[i] && tbl_key[i] == q.lookup_key) tbl_valid[i] = 1'b0;
        pending_words.push_back(summary(ttl_pkg::StatOk, 5'd0));
      end
      ttl_pkg::ReqFind: begin
        if (lim == 0) begin
          pending_words.push_back(summary(ttl_pkg::StatInvalid, 5'd0));
        end else begin
          if (lim > int'(ttl_pkg::FindCap)) lim = int'(ttl_pkg::FindCap);
          expire_stale();
          for (int i = 0; i < ttl_pkg::Entries; i++) begin
            if (tbl_valid[i] && tbl_key[i] == q.lookup_key) begin
              if (found < lim) begin
                r = '0;
                r.result_kind = ttl_pkg::KindData;
                r.match_data = tbl_data[i];
                pending_words.push_back(r);
              end
              found++;
            end
          end
          pending_words.push_back(summary(found > lim ? ttl_pkg::StatNoSpace
                                                      : ttl_pkg::StatOk,
                                          5'(found > 31 ? 31 : found)));
        end
      end
      ttl_pkg::ReqFlush: begin
        for (int i = 0; i < ttl_pkg::Entries; i++) tbl_valid[i] = 1'b0;
        pending_words.push_back(summary(ttl_pkg::StatOk, 5'd0));
      end
      default: pending_words.push_back(summary(ttl_pkg::StatInvalid, 5'd0));
    endcase
  endfunction

  // drives one request word and waits for its acceptance
  task automatic send_request(ttl_pkg::req_t q);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= q;
    req_valid_i <= 1'b1;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    predict_request(q);
    @(negedge clk_i);
  endtask

  function automatic ttl_pkg::req_t make_request(logic [2:0] kind,
                                                 logic [ttl_pkg::KeyW-1:0] k,
                                                 logic [ttl_pkg::TtlW-1:0] ttl,
                                                 logic [4:0] lim);
    ttl_pkg::req_t q;
    q.req_type = kind;
    q.lookup_key = k;
    q.entry_data = {$urandom, $urandom};
    q.ttl_seconds = ttl;
    q.max_matches = lim;
    return q;
  endfunction

  task automatic tick_ms(int n);
    for (int i = 0; i < n; i++)
      send_request(make_request(ttl_pkg::ReqTick, '0, '0, '0));
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  // receiver stall: random idling, or a forced hold while hold_rsp is set
  always @(negedge clk_i) begin
    rsp_stall_i <= hold_rsp || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // checks every accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", rsp_o);
      end else begin
        ttl_pkg::rsp_t want;
        want = pending_words.pop_front();
        if (rsp_o.result_kind !== want.result_kind || rsp_o.match_data !== want.match_data ||
            rsp_o.status !== want.status || rsp_o.found_count !== want.found_count ||
            rsp_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p got %p", want, rsp_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // extremes, invalid arguments, unknown requests, flush
  task automatic test_directed();
    send_request(make_request(ttl_pkg::ReqFind, key_pool[0], 32'd1, 5'd0));
    send_request(make_request(ttl_pkg::ReqAdd, key_pool[0], 32'd0, 5'd1));
    send_request(make_request(ttl_pkg::ReqAdd, '1, '1, 5'd31));
    send_request(make_request(ttl_pkg::ReqFind, '1, '1, 5'd31));
    send_request(make_request(ttl_pkg::ReqAdd, '0, 32'd1, 5'd0));
    send_request(make_request(ttl_pkg::ReqFind, '0, 32'd1, 5'd1));
    for (int k = 5; k < 8; k++) send_request(make_request(3'(k), '1, '1, '1));
    send_request(make_request(ttl_pkg::ReqRemove, '1, 32'd1, 5'd1));
    send_request(make_request(ttl_pkg::ReqFind, '1, 32'd1, 5'd16));
    send_request(make_request(ttl_pkg::ReqFlush, '0, 32'd1, 5'd1));
    send_request(make_request(ttl_pkg::ReqFind, '0, 32'd1, 5'd17));
  endtask

  // overfill with one key: oldest replacement, no_space, limit above cap
  task automatic test_replacement();
    for (int i = 0; i < 18; i++) begin
      send_request(make_request(ttl_pkg::ReqAdd, key_pool[1], 32'd100, 5'd1));
      if (i % 3 == 0) tick_ms(1);
    end
    send_request(make_request(ttl_pkg::ReqFind, key_pool[1], 32'd1, 5'd3));
    send_request(make_request(ttl_pkg::ReqFind, key_pool[1], 32'd1, 5'd20));
  endtask

  // receiver holds off while the sender keeps offering finds
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_request(make_request(ttl_pkg::ReqFind, key_pool[1], 32'd1, 5'd16));
    join
    wait_drained();
  endtask

  task automatic test_random(int n);
    ttl_pkg::req_t q;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      q = make_request(ttl_pkg::ReqFind, key_pool[2'($urandom_range(3))],
                       $urandom_range(1, 3), 5'($urandom_range(1, 17)));
      if (sel < 30) q.req_type = ttl_pkg::ReqTick;
      else if (sel < 60) q.req_type = ttl_pkg::ReqAdd;
      else if (sel < 72) q.req_type = ttl_pkg::ReqRemove;
      else if (sel < 90) q.req_type = ttl_pkg::ReqFind;
      else if (sel < 92) q.req_type = ttl_pkg::ReqFlush;
      else begin
        // noise: full random fields
        q.req_type = 3'($urandom);
        q.lookup_key = {$urandom, $urandom};
        q.ttl_seconds = $urandom;
        q.max_matches = 5'($urandom);
      end
      send_request(q);
    end
  endtask

  initial begin
    for (int i = 0; i < ttl_pkg::Entries; i++) tbl_valid[i] = 1'b0;
    now_ms = '0;
    key_pool[0] = 64'h0123_4567_89ab_cdef;
    key_pool[1] = 64'hfedc_ba98_7654_3210;
    key_pool[2] = 64'h5555_aaaa_5555_aaaa;
    key_pool[3] = 64'h0000_0000_0000_0001;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_replacement();
    wait_drained();
    test_backpressure();
    send_idle_pct = 11;
    recv_idle_pct = 54;
    test_random(88);
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 11;
    test_random(88);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(88);
    wait_drained();
    $display("covered tick, add, remove, find, flush, unknown requests, replacement, stalls");
    $display("%0d result words checked, %0d mismatches", words_seen, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
